FILE: hw/rtl/prs_pkg.sv
// ----------------------------------------------------------------------------
// prs_pkg: shared types and constants of the PageRank edge stream engine
// Vertex sizing, request codes, the front-to-back queue item and the states
// of the back-end sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
package prs_pkg;

  localparam int unsigned MaxVertices = 1024;
  localparam int unsigned VertexW     = $clog2(MaxVertices);
  localparam int unsigned CountW      = VertexW + 1;
  localparam int unsigned RankW       = 32;
  localparam int unsigned DampW       = 16;
  localparam int unsigned QueueDepth  = 2;

  localparam logic [DampW-1:0] DampingReset = 16'd55706;
  localparam logic [RankW-1:0] RankReset    = 32'(64'h8000_0000 / MaxVertices);
  localparam logic [RankW-1:0] RankMax      = '1;

  // Request codes as they arrive on the input stream.
  localparam logic [2:0] ReqCount  = 3'd0;
  localparam logic [2:0] ReqBegin  = 3'd1;
  localparam logic [2:0] ReqProp   = 3'd2;
  localparam logic [2:0] ReqEnd    = 3'd3;
  localparam logic [2:0] ReqRead   = 3'd4;

  typedef enum logic [2:0] {
    OP_COUNT,
    OP_BEGIN,
    OP_PROP,
    OP_END,
    OP_READ,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [VertexW-1:0] src;
    logic [VertexW-1:0] dst;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CE_WR,
    ST_PROP_WR,
    ST_READ_OUT,
    ST_BEG_RD,
    ST_BEG_MUL,
    ST_BEG_DIVS,
    ST_BEG_DIVW,
    ST_BASE_DIVS,
    ST_BASE_DIVW,
    ST_FILL,
    ST_END_RD,
    ST_END_WR
  } state_e;

endpackage
`default_nettype wire

FILE: hw/rtl/prs_ram.sv
// ----------------------------------------------------------------------------
// prs_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module prs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/prs_front.sv
// ----------------------------------------------------------------------------
// prs_front: request intake and queue
// Decodes each incoming word into an operation and holds it in a short queue
// until the back end takes it.
// ----------------------------------------------------------------------------
`default_nettype none
module prs_front import prs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [23:0] s_tdata_i,
  output queue_head_t      head_o,
  input  wire logic        pop_i
);

  localparam int unsigned PtrW = $clog2(QueueDepth);

  item_t           entry_q [QueueDepth];
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [PtrW:0]   fill_q, fill_d;
  item_t           decoded;
  logic            push;

  always_comb begin
    case (s_tdata_i[2:0])
      ReqCount: decoded.op = OP_COUNT;
      ReqBegin: decoded.op = OP_BEGIN;
      ReqProp:  decoded.op = OP_PROP;
      ReqEnd:   decoded.op = OP_END;
      ReqRead:  decoded.op = OP_READ;
      default:  decoded.op = OP_NONE;
    endcase
    decoded.src = s_tdata_i[12:3];
    decoded.dst = s_tdata_i[22:13];
  end

  assign s_tready_o = (fill_q != (PtrW+1)'(QueueDepth));
  assign push       = s_tvalid_i && s_tready_o;
  assign head_o.valid = (fill_q != '0);
  assign head_o.item  = entry_q[rd_ptr_q];

  always_comb begin
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
      fill_d   = fill_d + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
      fill_d   = fill_d - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= decoded;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/prs_div.sv
// ----------------------------------------------------------------------------
// prs_div: iterative unsigned divider
// Restoring division of a 32-bit dividend by a nonzero 32-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module prs_div import prs_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [RankW-1:0] dividend_i,
  input  wire logic [RankW-1:0] divisor_i,
  output logic                  done_o,
  output logic      [RankW-1:0] quot_o
);

  localparam int unsigned StepW = $clog2(RankW) + 1;

  logic [RankW-1:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [StepW-1:0] step_q, step_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [RankW:0]   shifted;

  assign shifted = {rem_q, quo_q[RankW-1]};
  assign done_o  = done_q;
  assign quot_o  = quo_q;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      step_d = StepW'(RankW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d = RankW'(shifted - {1'b0, dvs_q});
        quo_d = {quo_q[RankW-2:0], 1'b1};
      end else begin
        rem_d = shifted[RankW-1:0];
        quo_d = {quo_q[RankW-2:0], 1'b0};
      end
      step_d = step_q - 1'b1;
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/prs_back.sv
// ----------------------------------------------------------------------------
// prs_back: execution sequencer
// Runs each queued operation against the degree, rank and next-rank memories
// and loads the result word into the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module prs_back import prs_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [DampW-1:0] cfg_wdata_i,
  input  queue_head_t           head_i,
  output logic                  pop_o,
  output logic                  m_tvalid_o,
  input  wire logic             m_tready_i,
  output logic      [47:0]      m_tdata_o
);

  state_e             state_q, state_d;
  logic [CountW-1:0]  idx_q, idx_d, cnt_q, cnt_d;
  logic [DampW-1:0]   damp_q;
  item_t              cur_q, cur_d;
  logic [RankW-1:0]   prod_q, prod_d, dvs_q, dvs_d, base_q, base_d;
  logic [47:0]        mul;
  logic [CountW-1:0]  src_cnt, dst_cnt, idx_inc;

  logic               out_valid_q;
  logic [RankW-1:0]   out_rank_q;
  logic [CountW-1:0]  out_cnt_q;
  logic               out_err_q;
  logic               finish;
  logic [RankW-1:0]   fin_rank;
  logic               fin_err;

  logic               deg_we, rank_we, next_we;
  logic [VertexW-1:0] deg_wa, rank_wa, next_wa, deg_ra, rank_ra, next_ra;
  logic [RankW-1:0]   deg_wd, rank_wd, next_wd, deg_rd, rank_rd, next_rd;

  logic               div_start, div_done;
  logic [RankW-1:0]   div_a, div_b, div_q;
  logic [RankW:0]     sum;

  prs_ram #(.Width(RankW), .Depth(MaxVertices)) u_deg_ram (
    .clk_i, .we_i(deg_we), .waddr_i(deg_wa), .wdata_i(deg_wd),
    .raddr_i(deg_ra), .rdata_o(deg_rd)
  );
  prs_ram #(.Width(RankW), .Depth(MaxVertices)) u_rank_ram (
    .clk_i, .we_i(rank_we), .waddr_i(rank_wa), .wdata_i(rank_wd),
    .raddr_i(rank_ra), .rdata_o(rank_rd)
  );
  prs_ram #(.Width(RankW), .Depth(MaxVertices)) u_next_ram (
    .clk_i, .we_i(next_we), .waddr_i(next_wa), .wdata_i(next_wd),
    .raddr_i(next_ra), .rdata_o(next_rd)
  );

  prs_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_a), .divisor_i(div_b),
    .done_o(div_done), .quot_o(div_q)
  );

  assign mul     = rank_rd * damp_q;
  assign src_cnt = {1'b0, head_i.item.src} + 1'b1;
  assign dst_cnt = {1'b0, head_i.item.dst} + 1'b1;
  assign idx_inc = idx_q + 1'b1;
  assign sum     = {1'b0, next_rd} + {1'b0, rank_rd};

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    cur_d     = cur_q;
    prod_d    = prod_q;
    dvs_d     = dvs_q;
    base_d    = base_q;
    pop_o     = 1'b0;
    finish    = 1'b0;
    fin_rank  = '0;
    fin_err   = 1'b0;
    deg_we    = 1'b0;
    rank_we   = 1'b0;
    next_we   = 1'b0;
    deg_wa    = idx_q[VertexW-1:0];
    rank_wa   = idx_q[VertexW-1:0];
    next_wa   = idx_q[VertexW-1:0];
    deg_wd    = '0;
    rank_wd   = next_rd;
    next_wd   = base_q;
    deg_ra    = idx_q[VertexW-1:0];
    rank_ra   = idx_q[VertexW-1:0];
    next_ra   = idx_q[VertexW-1:0];
    div_start = 1'b0;
    div_a     = prod_q;
    div_b     = dvs_q;
    case (state_q)
      ST_CLEAR: begin
        deg_we  = 1'b1;
        rank_we = 1'b1;
        next_we = 1'b1;
        rank_wd = RankReset;
        next_wd = '0;
        idx_d   = idx_inc;
        if (idx_q == CountW'(MaxVertices - 1)) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (head_i.valid && !out_valid_q) begin
          pop_o   = 1'b1;
          cur_d   = head_i.item;
          idx_d   = '0;
          deg_ra  = head_i.item.src;
          rank_ra = head_i.item.src;
          next_ra = head_i.item.dst;
          // Every 10-bit vertex index lies inside the stores, so only begin
          // on an empty graph can fail.
          case (head_i.item.op)
            OP_COUNT: begin
              if (src_cnt > cnt_d) cnt_d = src_cnt;
              if (dst_cnt > cnt_d) cnt_d = dst_cnt;
              state_d = ST_CE_WR;
            end
            OP_BEGIN: begin
              if (cnt_q == '0) begin
                finish  = 1'b1;
                fin_err = 1'b1;
              end else begin
                state_d = ST_BEG_RD;
              end
            end
            OP_PROP: state_d = ST_PROP_WR;
            OP_END: begin
              if (cnt_q == '0) finish = 1'b1;
              else state_d = ST_END_RD;
            end
            OP_READ: state_d = ST_READ_OUT;
            default: finish = 1'b1;
          endcase
        end
      end
      ST_CE_WR: begin
        deg_we  = 1'b1;
        deg_wa  = cur_q.src;
        deg_wd  = (deg_rd == RankMax) ? deg_rd : deg_rd + 1'b1;
        finish  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_PROP_WR: begin
        next_we = 1'b1;
        next_wa = cur_q.dst;
        next_wd = sum[RankW] ? RankMax : sum[RankW-1:0];
        finish  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_READ_OUT: begin
        fin_rank = rank_rd;
        finish   = 1'b1;
        state_d  = ST_IDLE;
      end
      ST_BEG_RD: state_d = ST_BEG_MUL;
      ST_BEG_MUL: begin
        if (deg_rd == '0) begin
          idx_d   = idx_inc;
          state_d = (idx_inc == cnt_q) ? ST_BASE_DIVS : ST_BEG_RD;
        end else begin
          // Dividing by degree * 2^16 equals dividing the top bits by degree.
          prod_d  = mul[47:16];
          dvs_d   = deg_rd;
          state_d = ST_BEG_DIVS;
        end
      end
      ST_BEG_DIVS: begin
        div_start = 1'b1;
        state_d   = ST_BEG_DIVW;
      end
      ST_BEG_DIVW: begin
        if (div_done) begin
          rank_we = 1'b1;
          rank_wd = div_q;
          idx_d   = idx_inc;
          state_d = (idx_inc == cnt_q) ? ST_BASE_DIVS : ST_BEG_RD;
        end
      end
      ST_BASE_DIVS: begin
        div_start = 1'b1;
        div_a     = {(17'h1_0000 - {1'b0, damp_q}), 15'd0};
        div_b     = RankW'(cnt_q);
        state_d   = ST_BASE_DIVW;
      end
      ST_BASE_DIVW: begin
        if (div_done) begin
          base_d  = div_q;
          idx_d   = '0;
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        next_we = 1'b1;
        idx_d   = idx_inc;
        if (idx_inc == cnt_q) begin
          finish  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_END_RD: state_d = ST_END_WR;
      ST_END_WR: begin
        rank_we = 1'b1;
        idx_d   = idx_inc;
        if (idx_inc == cnt_q) begin
          finish  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          state_d = ST_END_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      idx_q       <= '0;
      cnt_q       <= '0;
      damp_q      <= DampingReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) damp_q <= cfg_wdata_i;
      if (finish) out_valid_q <= 1'b1;
      else if (m_tready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    prod_q <= prod_d;
    dvs_q  <= dvs_d;
    base_q <= base_d;
    if (finish) begin
      out_rank_q <= fin_rank;
      out_cnt_q  <= cnt_q;
      out_err_q  <= fin_err;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {4'd0, out_err_q, out_cnt_q, out_rank_q};

endmodule
`default_nettype wire

FILE: hw/rtl/pagerank_edge_stream_engine.sv
// ----------------------------------------------------------------------------
// pagerank_edge_stream_engine: fixed-point PageRank over streamed edges
//
//   channel  direction  payload
//   s_axis   in         tdata[2:0] req_type, [12:3] src_vertex, [22:13] dst_vertex
//   m_axis   out        tdata[31:0] rank_value, [42:32] vertex_total, [43] error_flag
//   cfg      in         damping, written when cfg_we_i is high
//
// Count and propagate are a read-modify-write of the registered-read memories;
// read is a plain registered read. Begin scales the rank of each vertex with
// out-edges through the bit-serial divider and skips the others, then divides
// out the base rank and fills the next-rank store with it. End copies the
// next-rank store into the rank store. After reset a clearing pass over all
// 1024 entries initializes the memories; the queue still takes up to two words
// meanwhile. A stalled output holds the back end while the queue keeps accepting.
// ----------------------------------------------------------------------------
`default_nettype none
module pagerank_edge_stream_engine import prs_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [23:0] s_tdata_i,  // req_type, src_vertex, dst_vertex
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic      [47:0] m_tdata_o   // rank_value, vertex_total, error_flag
);

  queue_head_t head;
  logic        pop;

  prs_front u_front (
    .clk_i, .rst_ni, .s_tvalid_i, .s_tready_o, .s_tdata_i,
    .head_o(head), .pop_i(pop)
  );

  prs_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .head_i(head), .pop_o(pop),
    .m_tvalid_o, .m_tready_i, .m_tdata_o
  );

endmodule
`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for pagerank_edge_stream_engine
// Streams edge counts, PageRank iterations, reads and noise into the engine,
// predicts every output word from its own copy of the vertex stores and
// compares field by field, under random idling and a long output hold.
// ----------------------------------------------------------------------------
module testbench;
  import prs_pkg::*;

  localparam int WatchdogLimit = 300000;
  localparam logic [2:0] ReqSpareLo  = 3'd5;
  localparam logic [2:0] ReqSpareMid = 3'd6;
  localparam logic [2:0] ReqSpareHi  = 3'd7;

  typedef struct packed {
    logic [2:0] kind;
    logic [9:0] src;
    logic [9:0] dst;
  } request_t;

  typedef struct packed {
    logic [31:0] rank;
    logic [10:0] total;
    logic        err;
  } rank_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [23:0] s_tdata_i = '0;   // req_type, src_vertex, dst_vertex
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [47:0] m_tdata_o;        // rank_value, vertex_total, error_flag

  pagerank_edge_stream_engine dut (.*);

  always #1 clk_i = ~clk_i;

  // Engine copy of the stores and the damping register.
  logic [31:0] degree_q [MaxVertices];
  logic [31:0] rank_q   [MaxVertices];
  logic [31:0] next_q   [MaxVertices];
  logic [10:0] vertex_count;
  logic [15:0] damping_q;

  request_t   pending_reqs[$];
  rank_word_t expected_words[$];
  request_t   edge_list[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int phase_no = 0;
  int mismatches = 0;
  int hold_cnt = 0;
  bit held = 1'b0;
  int quiet_cycles = 0;

  function automatic rank_word_t predict_word(request_t r);
    rank_word_t w;
    logic [63:0] num, den, base;
    logic [32:0] sum;
    w = '0;
    case (r.kind)
      ReqCount: begin
        if (11'(r.src) + 11'd1 > vertex_count) vertex_count = 11'(r.src) + 11'd1;
        if (11'(r.dst) + 11'd1 > vertex_count) vertex_count = 11'(r.dst) + 11'd1;
        if (degree_q[r.src] != RankMax) degree_q[r.src] = degree_q[r.src] + 1;
      end
      ReqBegin: begin
        if (vertex_count == 0) begin
          w.err = 1'b1;
        end else begin
          for (int i = 0; i < vertex_count; i++) begin
            if (degree_q[i] != 0) begin
              num = 64'(rank_q[i]) * 64'(damping_q);
              den = 64'(degree_q[i]) << 16;
              rank_q[i] = 32'(num / den);
            end
          end
          base = (64'(17'h10000 - 17'(damping_q)) << 15) / 64'(vertex_count);
          for (int i = 0; i < vertex_count; i++) next_q[i] = 32'(base);
        end
      end
      ReqProp: begin
        sum = 33'(next_q[r.dst]) + 33'(rank_q[r.src]);
        next_q[r.dst] = sum[32] ? RankMax : sum[31:0];
      end
      ReqEnd: for (int i = 0; i < vertex_count; i++) rank_q[i] = next_q[i];
      ReqRead: w.rank = rank_q[r.src];
      default: ;
    endcase
    w.total = vertex_count;
    return w;
  endfunction

  // Sender: a word stays offered until it is taken.
  always @(posedge clk_i) begin
    if (!s_tvalid_i || s_tready_o) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        request_t r;
        r = pending_reqs.pop_front();
        s_tvalid_i <= 1'b1;
        s_tdata_i  <= {1'b0, r.dst, r.src, r.kind};
      end else begin
        s_tvalid_i <= 1'b0;
      end
    end
  end

  // Receiver, with one long hold at the start of the last random phase.
  always @(posedge clk_i) begin
    if (phase_no == 3 && !held) begin
      held <= 1'b1;
      hold_cnt <= 600;
      m_tready_i <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready_i <= 1'b0;
    end else begin
      m_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_tvalid_i && s_tready_o)
      expected_words.push_back(predict_word(request_t'({s_tdata_i[2:0], s_tdata_i[12:3],
                                                        s_tdata_i[22:13]})));
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      rank_word_t got, want;
      got.rank  = m_tdata_o[31:0];
      got.total = m_tdata_o[42:32];
      got.err   = m_tdata_o[43];
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", m_tdata_o);
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: rank %h/%h total %0d/%0d err %b/%b (exp/act)",
                     want.rank, got.rank, want.total, got.total, want.err, got.err);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic emit(logic [2:0] kind, int src, int dst);
    request_t r;
    r.kind = kind;
    r.src = 10'(src);
    r.dst = 10'(dst);
    pending_reqs.push_back(r);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || s_tvalid_i || expected_words.size() != 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_damping(logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    damping_q = value;
  endtask

  // Mostly well-formed iterations over a small graph, the rest noise.
  task automatic random_phase(int items);
    int n, s, d;
    request_t e;
    n = 0;
    while (n < items) begin
      case ($urandom_range(9))
        0, 1: begin
          s = $urandom_range(31);
          d = $urandom_range(31);
          emit(ReqCount, s, d);
          if (edge_list.size() < 24) begin
            e.kind = ReqProp;
            e.src = 10'(s);
            e.dst = 10'(d);
            edge_list.push_back(e);
          end
          n++;
        end
        2, 3, 4, 5, 6: begin
          emit(ReqBegin, $urandom_range(1023), $urandom_range(1023));
          foreach (edge_list[i]) emit(ReqProp, edge_list[i].src, edge_list[i].dst);
          emit(ReqEnd, $urandom_range(1023), $urandom_range(1023));
          repeat (3) emit(ReqRead, $urandom_range(33), $urandom_range(1023));
          n += edge_list.size() + 5;
        end
        7: begin
          emit(ReqProp, $urandom_range(1023), $urandom_range(1023));
          emit(ReqRead, $urandom_range(1023), $urandom_range(1023));
          emit(3'($urandom_range(5, 7)), $urandom_range(1023), $urandom_range(1023));
          n += 3;
        end
        default: begin
          if ($urandom_range(3) == 0) emit(ReqBegin, 0, 0);
          else emit(ReqEnd, 0, 0);
          emit(ReqRead, $urandom_range(1023), 0);
          n += 2;
        end
      endcase
    end
  endtask

  initial begin
    for (int i = 0; i < MaxVertices; i++) begin
      degree_q[i] = '0;
      rank_q[i] = RankReset;
      next_q[i] = '0;
    end
    vertex_count = '0;
    damping_q = DampingReset;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: begin and end with no vertices, extremes, unknown codes.
    emit(ReqBegin, 0, 0);
    emit(ReqEnd, 0, 0);
    emit(ReqRead, 1023, 0);
    emit(ReqRead, 0, 1023);
    emit(ReqProp, 1023, 1023);
    emit(ReqProp, 0, 1023);
    emit(ReqSpareLo, 1023, 1023);
    emit(ReqSpareMid, 0, 0);
    emit(ReqSpareHi, 682, 341);
    emit(ReqCount, 0, 1);
    emit(ReqCount, 1, 2);
    emit(ReqCount, 2, 0);
    emit(ReqCount, 0, 2);
    emit(ReqBegin, 0, 0);
    emit(ReqProp, 0, 1);
    emit(ReqProp, 1, 2);
    emit(ReqProp, 2, 0);
    emit(ReqProp, 0, 2);
    emit(ReqEnd, 0, 0);
    emit(ReqRead, 0, 0);
    emit(ReqRead, 2, 0);
    emit(ReqRead, 5, 0);
    wait_drained();

    write_damping(16'd0);
    send_idle_pct = 17;
    recv_idle_pct = 74;
    phase_no = 1;
    random_phase(620);
    wait_drained();

    write_damping(16'hFFFF);
    send_idle_pct = 74;
    recv_idle_pct = 17;
    phase_no = 2;
    random_phase(620);
    wait_drained();

    write_damping(16'd30000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    phase_no = 3;
    random_phase(620);
    wait_drained();

    // Grow to full capacity once; each begin now walks every vertex.
    write_damping(DampingReset);
    emit(ReqCount, 1023, 1023);
    emit(ReqCount, 0, 1023);
    emit(ReqBegin, 0, 0);
    emit(ReqProp, 1023, 0);
    emit(ReqProp, 0, 1023);
    emit(ReqEnd, 0, 0);
    emit(ReqRead, 1023, 0);
    emit(ReqRead, 0, 0);
    emit(ReqRead, 512, 0);
    wait_drained();

    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

FILE: pagerank_edge_stream_engine.f
hw/rtl/prs_pkg.sv
hw/rtl/prs_ram.sv
hw/rtl/prs_front.sv
hw/rtl/prs_div.sv
hw/rtl/prs_back.sv
hw/rtl/pagerank_edge_stream_engine.sv
tb/testbench.sv
